// File: hdl/sta_lta_event_trigger_defines.svh
// -----------------------------------------------------------------------------
// sta_lta_event_trigger_defines
// assertion macros shared by the sta/lta trigger rtl
// -----------------------------------------------------------------------------
`ifndef STA_LTA_EVENT_TRIGGER_DEFINES_SVH
`define STA_LTA_EVENT_TRIGGER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define STALT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stalt assertion failed");
// next-cycle implication, checked out of reset
`define STALT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stalt assertion failed");
`else
`define STALT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STALT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/stalt_pkg.sv
// -----------------------------------------------------------------------------
// stalt_pkg
// widths, register indexes, sequencer states and helpers for the sta/lta trigger
// -----------------------------------------------------------------------------
package stalt_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SAMPLE_W      = 16;
    localparam int SUM_W         = 26;
    localparam int LEN_W         = 10;
    localparam int THR_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int OUT_DATA_W    = 56;
    localparam int IDX_W         = ((HIST_AW > LEN_W) ? HIST_AW : LEN_W) + 1;

    // product widths for the cross-multiplied ratio test
    localparam int PSL_W = SUM_W + LEN_W;
    localparam int PTL_W = THR_W + SUM_W;
    localparam int CMP_W = PTL_W + LEN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR = 2'd2;

    typedef logic [HIST_AW-1:0] t_hist_addr;

    typedef struct packed {
        logic                wr_en;
        t_hist_addr          wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        t_hist_addr          rd_addr;
    } t_hist_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_L,
        ST_UPD_L,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } t_state;

    // zero length acts as one; lengths beyond the ring are clamped
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (int'(n) > HISTORY_DEPTH - 1) begin
            n = LEN_W'(HISTORY_DEPTH - 1);
        end
        return n;
    endfunction

    // ring position one window back from pos
    function automatic t_hist_addr back_index(input t_hist_addr pos,
                                              input logic [LEN_W-1:0] len);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] r;
        p = IDX_W'(pos);
        l = IDX_W'(len);
        if (p >= l) begin
            r = p - l;
        end else begin
            r = p + IDX_W'(HISTORY_DEPTH) - l;
        end
        return r[HIST_AW-1:0];
    endfunction

endpackage

// File: hdl/stalt_history.sv
// -----------------------------------------------------------------------------
// stalt_history
// sample history ring: one write port, one read port, registered read data
// -----------------------------------------------------------------------------
module stalt_history (
    input  logic                          i_clk,
    input  stalt_pkg::t_hist_req          i_req,
    output logic [stalt_pkg::SAMPLE_W-1:0] o_rd_data
);
    import stalt_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/sta_lta_event_trigger.sv
// -----------------------------------------------------------------------------
// sta_lta_event_trigger
// sequence: RD_L, UPD_L, MUL1, MUL2 and OUT, then the output register; OUT holds
//   while a result is unclaimed, and a new sample is taken only back in IDLE, set by
//   the two history reads through the single ring read port and the two-step cross-multiplication
// reset (synchronous, active low): sums, ring pointer and sample count clear,
//   registers return to 32 / 512 / 768; the ring itself needs no clearing pass
// -----------------------------------------------------------------------------
`include "sta_lta_event_trigger_defines.svh"

module sta_lta_event_trigger (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [stalt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stalt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample input
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,  // [15:0] adc_sample
    // result output
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] windows_full, [1] event_trigger, [27:2] short_sum, [53:28] long_sum,
    // [55:54] zero
    output logic [stalt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import stalt_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]    r_cfg_slen;
    logic [LEN_W-1:0]    r_cfg_llen;
    logic [THR_W-1:0]    r_cfg_thr;

    // sequencer
    t_state              r_state;
    t_state              n_state;
    logic                s_in_xfer;
    logic                s_out_load;

    // running state
    t_hist_addr          r_wr_ptr;
    logic [LEN_W-1:0]    r_seen;
    logic [SUM_W-1:0]    r_short;
    logic [SUM_W-1:0]    r_long;

    // per-sample working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic [LEN_W-1:0]    r_slen;
    logic [LEN_W-1:0]    r_llen;
    logic [THR_W-1:0]    r_thr;
    t_hist_addr          r_addr_l;
    logic                r_sub_s;
    logic                r_sub_l;
    logic                r_full;
    logic [PSL_W-1:0]    r_p_sl;
    logic [PTL_W-1:0]    r_p_tl;
    logic [CMP_W-1:0]    r_lhs;
    logic [CMP_W-1:0]    r_rhs;

    // output register
    logic                r_out_valid;
    logic                r_out_full;
    logic                r_out_trig;
    logic [SUM_W-1:0]    r_out_short;
    logic [SUM_W-1:0]    r_out_long;

    // ring interface
    t_hist_req           s_hist_req;
    logic [SAMPLE_W-1:0] s_rd_data;

    // window lengths as seen by the arriving sample
    logic [LEN_W-1:0]    s_slen;
    logic [LEN_W-1:0]    s_llen;
    logic [LEN_W-1:0]    s_seen_next;

    assign s_slen      = eff_len(r_cfg_slen);
    assign s_llen      = eff_len(r_cfg_llen);
    assign s_seen_next = (r_seen == '1) ? r_seen : r_seen + LEN_W'(1);

    // config writes, taken whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slen <= LEN_W'(32);
            r_cfg_llen <= LEN_W'(512);
            r_cfg_thr  <= THR_W'(768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_LEN: begin
                    r_cfg_slen <= i_cfg_data[LEN_W-1:0];
                end
                CFG_LONG_LEN: begin
                    r_cfg_llen <= i_cfg_data[LEN_W-1:0];
                end
                CFG_RATIO_THR: begin
                    r_cfg_thr <= i_cfg_data[THR_W-1:0];
                end
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        s_out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_RD_L;
                end
            end
            ST_RD_L: begin
                n_state = ST_UPD_L;
            end
            ST_UPD_L: begin
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait here only while an earlier result is still unclaimed
                if (!r_out_valid || i_m_axis_tready) begin
                    s_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // ring access: the new sample is written on the transfer itself; the short
    // window's leaving sample is read in that same cycle, the long one next
    always_comb begin
        s_hist_req.wr_en   = s_in_xfer;
        s_hist_req.wr_addr = r_wr_ptr;
        s_hist_req.wr_data = i_s_axis_tdata[SAMPLE_W-1:0];
        if (r_state == ST_IDLE) begin
            s_hist_req.rd_addr = back_index(r_wr_ptr, s_slen);
        end else begin
            s_hist_req.rd_addr = r_addr_l;
        end
    end

    stalt_history u_history (
        .i_clk     (i_clk),
        .i_req     (s_hist_req),
        .o_rd_data (s_rd_data)
    );

    // control state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_seen   <= '0;
            r_short  <= '0;
            r_long   <= '0;
        end else begin
            if (s_in_xfer) begin
                if (r_wr_ptr == HIST_AW'(HISTORY_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + HIST_AW'(1);
                end
                r_seen <= s_seen_next;
            end
            // short sum: add the new sample, drop the leaving one once full
            if (r_state == ST_RD_L) begin
                r_short <= r_short + SUM_W'(r_sample)
                           - (r_sub_s ? SUM_W'(s_rd_data) : SUM_W'(0));
            end
            if (r_state == ST_UPD_L) begin
                r_long <= r_long + SUM_W'(r_sample)
                          - (r_sub_l ? SUM_W'(s_rd_data) : SUM_W'(0));
            end
        end
    end

    // per-sample datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
            r_slen   <= s_slen;
            r_llen   <= s_llen;
            r_thr    <= r_cfg_thr;
            r_addr_l <= back_index(r_wr_ptr, s_llen);
            r_sub_s  <= (r_seen >= s_slen);
            r_sub_l  <= (r_seen >= s_llen);
            r_full   <= (s_seen_next >= s_slen) && (s_seen_next >= s_llen);
        end
        // first products: short sum by long length, threshold by long sum
        if (r_state == ST_MUL1) begin
            r_p_sl <= PSL_W'(r_short) * PSL_W'(r_llen);
            r_p_tl <= PTL_W'(r_thr) * PTL_W'(r_long);
        end
        // second step: q8.8 scale on the left, short length on the right
        if (r_state == ST_MUL2) begin
            r_lhs <= CMP_W'({r_p_sl, 8'b0});
            r_rhs <= CMP_W'(r_p_tl) * CMP_W'(r_slen);
        end
        if (s_out_load) begin
            r_out_full  <= r_full;
            r_out_trig  <= r_full && (r_long != '0) && (r_lhs > r_rhs);
            r_out_short <= r_short;
            r_out_long  <= r_long;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_long, r_out_short, r_out_trig, r_out_full};

    // a transfer always starts the ring read sequence
    `STALT_ASSERT_NEXT(a_xfer_starts_seq, i_clk, i_rst_n, s_in_xfer, r_state == ST_RD_L)
    // a trigger needs both windows full
    `STALT_ASSERT_IMPLY(a_trig_needs_full, i_clk, i_rst_n, r_out_valid && r_out_trig, r_out_full)
    // a trigger never comes from an empty long window
    `STALT_ASSERT_IMPLY(a_trig_needs_long, i_clk, i_rst_n, r_out_valid && r_out_trig,
        r_out_long != '0)

endmodule

// File: tb/tb.sv
// -----------------------------------------------------------------------------
// tb
// self-checking bench for sta_lta_event_trigger: one adc sample per input
// transfer, one result per sample, each result compared field by field with a
// behavioural predictor of the running sums, window fill and ratio test
// -----------------------------------------------------------------------------
module tb;
    import stalt_pkg::*;

    // ring depth and sample counter ceiling as seen by the predictor
    localparam int RING_SLOTS    = 1024;
    localparam int SEEN_CAP      = 1023;
    // settle time after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int QUIET_RUN     = 64;

    // packed exactly as the result tdata, windows_full in bit 0
    typedef struct packed {
        logic [SUM_W-1:0] lta;
        logic [SUM_W-1:0] sta;
        logic             trig;
        logic             full;
    } trigger_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_SETTINGS
    } row_kind_t;

    // one line of the directed table; settings rows carry the three registers
    typedef struct {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]    s_len;
        logic [LEN_W-1:0]    l_len;
        logic [THR_W-1:0]    thr;
        logic                typed;
        logic                w_full;
        logic                w_trig;
        logic [SUM_W-1:0]    w_sta;
        logic [SUM_W-1:0]    w_lta;
    } stim_row_t;

    // dut side
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx       = CFG_SHORT_LEN;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [15:0]            i_s_axis_tdata  = '0;   // [15:0] adc_sample
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [0] windows_full, [1] event_trigger, [27:2] short_sum, [53:28] long_sum
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;

    // predictor state, matching the block straight after reset
    logic [SAMPLE_W-1:0]    ring [RING_SLOTS];
    logic [HIST_AW-1:0]     wr_pos    = '0;
    int unsigned            seen_cnt  = 0;
    logic [SUM_W-1:0]       sta_sum   = '0;
    logic [SUM_W-1:0]       lta_sum   = '0;
    logic [LEN_W-1:0]       cfg_short = LEN_W'(32);
    logic [LEN_W-1:0]       cfg_long  = LEN_W'(512);
    logic [THR_W-1:0]       cfg_thr   = THR_W'(768);

    trigger_result_t        results_due [$];
    int                     mismatches   = 0;
    int unsigned            tx_gap_pct   = 0;
    int unsigned            rx_stall_pct = 0;

    always #2 i_clk = ~i_clk;

    sta_lta_event_trigger i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // zero length behaves as one, anything past the ring is clamped
    function automatic int unsigned window_span(input logic [LEN_W-1:0] len);
        return (len == '0) ? 1 :
               ((int'(len) > RING_SLOTS - 1) ? RING_SLOTS - 1 : int'(len));
    endfunction

    // advance the sums by one sample and work out the result it produces
    function automatic trigger_result_t track_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned        sspan;
        int unsigned        lspan;
        int unsigned        prior;
        logic [HIST_AW-1:0] pos;
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        trigger_result_t    res;
        sspan = window_span(cfg_short);
        lspan = window_span(cfg_long);
        pos   = wr_pos;
        prior = seen_cnt;
        ring[pos] = value;
        sta_sum = sta_sum + SUM_W'(value);
        lta_sum = lta_sum + SUM_W'(value);
        // the leaving sample sits exactly one window behind the new one
        if (prior >= sspan) begin
            sta_sum = sta_sum - SUM_W'(ring[HIST_AW'(pos - HIST_AW'(sspan))]);
        end
        if (prior >= lspan) begin
            lta_sum = lta_sum - SUM_W'(ring[HIST_AW'(pos - HIST_AW'(lspan))]);
        end
        wr_pos = pos + 1'b1;
        if (seen_cnt < SEEN_CAP) begin
            seen_cnt++;
        end
        res.full = (seen_cnt >= sspan) && (seen_cnt >= lspan);
        res.sta  = sta_sum;
        res.lta  = lta_sum;
        res.trig = 1'b0;
        // exact ratio test by cross-multiplication, threshold in q8.8
        if (res.full && lta_sum != '0) begin
            lhs = 64'(sta_sum) * 64'(lspan) * 64'd256;
            rhs = 64'(cfg_thr) * 64'(lta_sum) * 64'(sspan);
            res.trig = lhs > rhs;
        end
        return res;
    endfunction

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        int spins;
        spins = 0;
        i_s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one transfer per sample; gaps only lower valid when one is actually taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input trigger_result_t given);
        trigger_result_t due;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        due = track_sample(value);
        results_due.push_back(typed ? given : due);
    endtask

    // all three registers, written back to back while the block is idle
    task automatic load_settings(input logic [LEN_W-1:0] s_len, input logic [LEN_W-1:0] l_len,
                                 input logic [THR_W-1:0] thr);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SHORT_LEN;
        i_cfg_data <= CFG_DATA_W'(s_len);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_LEN;
        i_cfg_data <= CFG_DATA_W'(l_len);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RATIO_THR;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_short = s_len;
        cfg_long  = l_len;
        cfg_thr   = thr;
    endtask

    // quiet background with bursts, some full-range noise and rail values;
    // a run of zeros first so the window change leaves the sums consistent
    task automatic run_phase(input int count, input logic [LEN_W-1:0] s_len,
                             input logic [LEN_W-1:0] l_len, input logic [THR_W-1:0] thr);
        int unsigned         burst_left;
        int unsigned         pick;
        logic [SAMPLE_W-1:0] value;
        burst_left = 0;
        repeat (QUIET_RUN) send_sample('0, 1'b0, '0);
        load_settings(s_len, l_len, thr);
        for (int n = 0; n < count; n++) begin
            // now and then hold the sender until the pipeline is empty
            if ($urandom_range(199) == 0) begin
                wait_drained();
            end
            if (burst_left != 0) begin
                burst_left--;
                value = SAMPLE_W'($urandom_range(65535, 2000));
            end else begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    burst_left = $urandom_range(24, 1);
                    value = SAMPLE_W'($urandom_range(65535, 2000));
                end else if (pick < 12) begin
                    value = SAMPLE_W'($urandom);
                end else if (pick < 16) begin
                    value = pick[0] ? '1 : '0;
                end else begin
                    value = SAMPLE_W'($urandom_range(300));
                end
            end
            send_sample(value, 1'b0, '0);
        end
    endtask

    // receiver stalls at the rate the current phase asks
    always @(posedge i_clk) begin
        if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // every result transfer is checked against the oldest expectation
    always @(posedge i_clk) begin : result_check
        trigger_result_t got;
        trigger_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = trigger_result_t'(o_m_axis_tdata[2*SUM_W+1:0]);
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, got);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got.full !== want.full) begin
                    $display("%0t: windows_full expected %0d got %0d",
                             $time, want.full, got.full);
                    mismatches++;
                end
                if (got.trig !== want.trig) begin
                    $display("%0t: event_trigger expected %0d got %0d",
                             $time, want.trig, got.trig);
                    mismatches++;
                end
                if (got.sta !== want.sta) begin
                    $display("%0t: short_sum expected %0d got %0d",
                             $time, want.sta, got.sta);
                    mismatches++;
                end
                if (got.lta !== want.lta) begin
                    $display("%0t: long_sum expected %0d got %0d",
                             $time, want.lta, got.lta);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t       directed_rows [$];
        trigger_result_t given;

        // windows 1 and 2 keep the sums small enough to type in; the first
        // row runs on the reset settings, the rest cover an empty long window,
        // the strict ratio boundary, both threshold rails and zero length
        directed_rows = '{
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b0, 1'b0, 26'd0,     26'd0},
            '{ROW_SETTINGS, 16'd0,     10'd0, 10'd2, 16'd256,   1'b0, 1'b0, 1'b0, 26'd0,     26'd0},
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd0,     26'd0},
            '{ROW_SAMPLE,   16'd65535, 10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b1, 26'd65535, 26'd65535},
            '{ROW_SAMPLE,   16'd65535, 10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd65535, 26'd131070},
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd0,     26'd65535},
            '{ROW_SAMPLE,   16'd1,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b1, 26'd1,     26'd1},
            '{ROW_SETTINGS, 16'd0,     10'd0, 10'd2, 16'd65535, 1'b0, 1'b0, 1'b0, 26'd0,     26'd0},
            '{ROW_SAMPLE,   16'd65535, 10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd65535, 26'd65536},
            '{ROW_SETTINGS, 16'd0,     10'd0, 10'd2, 16'd0,     1'b0, 1'b0, 1'b0, 26'd0,     26'd0},
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd0,     26'd65535},
            '{ROW_SAMPLE,   16'd5,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b1, 26'd5,     26'd5},
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd0,     26'd5},
            '{ROW_SAMPLE,   16'd0,     10'd0, 10'd0, 16'd0,     1'b1, 1'b1, 1'b0, 26'd0,     26'd0}
        };

        // reset held at the start, released once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gap_pct   = 34;
        rx_stall_pct = 55;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETTINGS) begin
                load_settings(directed_rows[i].s_len, directed_rows[i].l_len,
                              directed_rows[i].thr);
            end else begin
                given = {directed_rows[i].w_lta, directed_rows[i].w_sta,
                         directed_rows[i].w_trig, directed_rows[i].w_full};
                send_sample(directed_rows[i].sample, directed_rows[i].typed, given);
            end
        end

        // sender gappy and receiver stalling, then the other way round
        run_phase(520, LEN_W'(8), LEN_W'(64), THR_W'(768));
        tx_gap_pct   = 55;
        rx_stall_pct = 34;
        run_phase(520, LEN_W'(3), LEN_W'(24), THR_W'($urandom_range(1536, 256)));
        // flat out with both windows at their longest
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_phase(520, LEN_W'(1023), LEN_W'(1023), THR_W'($urandom_range(65535)));

        wait_drained();
        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            mismatches += results_due.size();
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
